// ===== hw/rtl/tile_scanline_renderer_core_macros.svh =====
// ----------------------------------------------------------------------------
// Tile scanline renderer assertion macros
// Shared assertion forms for the renderer RTL.
// ----------------------------------------------------------------------------
`ifndef TILE_SCANLINE_RENDERER_CORE_MACROS_SVH
`define TILE_SCANLINE_RENDERER_CORE_MACROS_SVH

// condition holds in the same cycle as the trigger
`define TSR_ASSERT_IMP(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define TSR_ASSERT_NXT(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== hw/rtl/tsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Tile scanline renderer package
// Types, constants and helpers shared by the renderer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tsr_pkg;

    localparam int LINE_WIDTH_DEF     = 160;
    localparam int LINE_COUNT_DEF     = 144;
    localparam int SPRITE_SLOTS_DEF   = 10;
    localparam int SPRITE_ENTRIES_DEF = 40;

    localparam int VRAM_BYTES   = 8192;
    localparam int VRAM_AW      = 13;
    localparam int ATTR_BYTES   = 160;
    localparam int ATTR_AW      = 8;
    localparam int ATTR_ENTRIES = 40;

    localparam logic [1:0] FUNC_VWRITE = 2'd0;
    localparam logic [1:0] FUNC_AWRITE = 2'd1;
    localparam logic [1:0] FUNC_RENDER = 2'd2;

    localparam logic [2:0] CFG_LCDC = 3'd0;
    localparam logic [2:0] CFG_SCY  = 3'd1;
    localparam logic [2:0] CFG_SCX  = 3'd2;
    localparam logic [2:0] CFG_BGP  = 3'd3;
    localparam logic [2:0] CFG_OBP0 = 3'd4;
    localparam logic [2:0] CFG_OBP1 = 3'd5;
    localparam logic [2:0] CFG_WY   = 3'd6;
    localparam logic [2:0] CFG_WX   = 3'd7;

    localparam logic [7:0] LCDC_RST = 8'h91;
    localparam logic [7:0] BGP_RST  = 8'hFC;
    localparam logic [7:0] OBP_RST  = 8'hFF;

    localparam logic [12:0] MAP_LO = 13'h1800;
    localparam logic [12:0] MAP_HI = 13'h1C00;
    localparam logic [7:0]  WX_MAX = 8'd166;

    typedef struct packed {
        logic [1:0]  func;
        logic [12:0] mem_addr;
        logic [7:0]  mem_data;
        logic [7:0]  line;
    } t_in;

    typedef struct packed {
        logic [15:0] pixels;
        logic [4:0]  group;
        logic        last;
    } t_out;

    typedef struct packed {
        logic clr;
        logic idle;
        logic start;
        logic bg0;
        logic bg1;
        logic bg2;
        logic bg3;
        logic win;
        logic sc0;
        logic sc1;
        logic sc2;
        logic pa0;
        logic pa1;
        logic pa2;
        logic pa3;
        logic pa4;
        logic pa5;
        logic pp0;
        logic pp1;
        logic orr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic go;
        logic x_last;
        logic spr_en;
        logic scan_done;
        logic slot_zero;
        logic p_last;
        logic q_last;
        logic g_last;
        logic out_free;
    } t_st;

    function automatic logic [1:0] shade_of(input logic [7:0] pal, input logic [1:0] idx);
        logic [1:0] s;
        unique case (idx)
            2'd0:    s = pal[1:0];
            2'd1:    s = pal[3:2];
            2'd2:    s = pal[5:4];
            default: s = pal[7:6];
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tsr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Tile scanline renderer controller
// Sequences clearing, background, sprite scan, sprite paint and output.
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_ctrl (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  tsr_pkg::t_st  i_st,
    output tsr_pkg::t_cmd o_cmd
);

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_BG0  = 5'd2;
    localparam logic [4:0] S_BG1  = 5'd3;
    localparam logic [4:0] S_BG2  = 5'd4;
    localparam logic [4:0] S_BG3  = 5'd5;
    localparam logic [4:0] S_WIN  = 5'd6;
    localparam logic [4:0] S_SC0  = 5'd7;
    localparam logic [4:0] S_SC1  = 5'd8;
    localparam logic [4:0] S_SC2  = 5'd9;
    localparam logic [4:0] S_PCHK = 5'd10;
    localparam logic [4:0] S_PA0  = 5'd11;
    localparam logic [4:0] S_PA1  = 5'd12;
    localparam logic [4:0] S_PA2  = 5'd13;
    localparam logic [4:0] S_PA3  = 5'd14;
    localparam logic [4:0] S_PA4  = 5'd15;
    localparam logic [4:0] S_PA5  = 5'd16;
    localparam logic [4:0] S_PP0  = 5'd17;
    localparam logic [4:0] S_PP1  = 5'd18;
    localparam logic [4:0] S_OR   = 5'd19;
    localparam logic [4:0] S_OUT  = 5'd20;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (i_st.clr_last) n_state = S_IDLE;
            S_IDLE: if (i_st.go) n_state = S_BG0;
            S_BG0:  n_state = S_BG1;
            S_BG1:  n_state = S_BG2;
            S_BG2:  n_state = S_BG3;
            S_BG3:  n_state = i_st.x_last ? S_WIN : S_BG0;
            S_WIN:  n_state = i_st.spr_en ? S_SC0 : S_OR;
            S_SC0:  n_state = S_SC1;
            S_SC1:  n_state = S_SC2;
            S_SC2:  n_state = i_st.scan_done ? S_PCHK : S_SC0;
            S_PCHK: n_state = i_st.slot_zero ? S_OR : S_PA0;
            S_PA0:  n_state = S_PA1;
            S_PA1:  n_state = S_PA2;
            S_PA2:  n_state = S_PA3;
            S_PA3:  n_state = S_PA4;
            S_PA4:  n_state = S_PA5;
            S_PA5:  n_state = S_PP0;
            S_PP0:  n_state = S_PP1;
            S_PP1:  n_state = i_st.p_last ? S_PCHK : S_PP0;
            S_OR:   if (i_st.q_last) n_state = S_OUT;
            S_OUT: begin
                if (i_st.out_free) begin
                    n_state = i_st.g_last ? S_IDLE : S_OR;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.clr      = (r_state == S_CLR);
    assign o_cmd.idle     = (r_state == S_IDLE);
    assign o_cmd.start    = (r_state == S_IDLE) && i_st.go;
    assign o_cmd.bg0      = (r_state == S_BG0);
    assign o_cmd.bg1      = (r_state == S_BG1);
    assign o_cmd.bg2      = (r_state == S_BG2);
    assign o_cmd.bg3      = (r_state == S_BG3);
    assign o_cmd.win      = (r_state == S_WIN);
    assign o_cmd.sc0      = (r_state == S_SC0);
    assign o_cmd.sc1      = (r_state == S_SC1);
    assign o_cmd.sc2      = (r_state == S_SC2);
    assign o_cmd.pa0      = (r_state == S_PA0);
    assign o_cmd.pa1      = (r_state == S_PA1);
    assign o_cmd.pa2      = (r_state == S_PA2);
    assign o_cmd.pa3      = (r_state == S_PA3);
    assign o_cmd.pa4      = (r_state == S_PA4);
    assign o_cmd.pa5      = (r_state == S_PA5);
    assign o_cmd.pp0      = (r_state == S_PP0);
    assign o_cmd.pp1      = (r_state == S_PP1);
    assign o_cmd.orr      = (r_state == S_OR);
    assign o_cmd.out_load = (r_state == S_OUT) && i_st.out_free;

endmodule

`default_nettype wire

// ===== hw/rtl/tsr_dp.sv =====
// ----------------------------------------------------------------------------
// Tile scanline renderer datapath
// Memories, configuration, line buffers, sprite list and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tile_scanline_renderer_core_macros.svh"

module tsr_dp #(
    parameter int LINE_WIDTH     = tsr_pkg::LINE_WIDTH_DEF,
    parameter int LINE_COUNT     = tsr_pkg::LINE_COUNT_DEF,
    parameter int SPRITE_SLOTS   = tsr_pkg::SPRITE_SLOTS_DEF,
    parameter int SPRITE_ENTRIES = tsr_pkg::SPRITE_ENTRIES_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  tsr_pkg::t_cmd  i_cmd,
    output tsr_pkg::t_st   o_st,
    input  wire            i_valid,
    input  tsr_pkg::t_in   i_item,
    input  wire            i_cfg_we,
    input  wire  [2:0]     i_cfg_idx,
    input  wire  [7:0]     i_cfg_data,
    output logic           o_valid,
    input  wire            i_stall,
    output tsr_pkg::t_out  o_item
);

    localparam int XW = $clog2(LINE_WIDTH);
    localparam int SW = (SPRITE_SLOTS > 1) ? $clog2(SPRITE_SLOTS) : 1;
    localparam int CW = $clog2(SPRITE_SLOTS + 1);
    localparam int NE = (SPRITE_ENTRIES < tsr_pkg::ATTR_ENTRIES) ?
                        SPRITE_ENTRIES : tsr_pkg::ATTR_ENTRIES;
    localparam int GROUPS = (LINE_WIDTH + 7) / 8;

    // configuration
    logic [7:0] r_lcdc, r_scy, r_scx, r_bgp, r_obp0, r_obp1, r_wy, r_wx;

    // control
    logic [12:0]   r_clr;
    logic [XW-1:0] r_x;
    logic [5:0]    r_e;
    logic [CW-1:0] r_cnt;
    logic [2:0]    r_p;
    logic [3:0]    r_q;
    logic [4:0]    r_g;
    logic [7:0]    r_wcnt;
    logic          r_ovalid;

    // payload
    logic [7:0]  r_line;
    logic        r_win;
    logic [12:0] r_raddr;
    logic [7:0]  r_lo, r_hi, r_y, r_tile, r_flags;
    logic [5:0]  r_sid [SPRITE_SLOTS];
    logic [7:0]  r_sx  [SPRITE_SLOTS];
    logic [5:0]  n_sid [SPRITE_SLOTS];
    logic [7:0]  n_sx  [SPRITE_SLOTS];
    logic        r_inr;
    logic [15:0] r_word;
    tsr_pkg::t_out r_out;

    // memories
    logic        vr_we;
    logic [12:0] vr_waddr, vr_raddr;
    logic [7:0]  vr_wdata, vr_rdata;
    logic        at_we;
    logic [7:0]  at_waddr, at_raddr, at_wdata, at_rdata;
    logic          bb_we;
    logic [XW-1:0] bb_waddr, bb_raddr;
    logic [1:0]    bb_wdata, bb_rdata;
    logic          sh_we;
    logic [XW-1:0] sh_waddr, sh_raddr;
    logic [1:0]    sh_wdata, sh_rdata;

    // background
    logic [7:0]  x8, px, py;
    logic        use_win;
    logic [12:0] map_origin, map_addr, tile_row;
    logic [1:0]  bg_idx;

    // sprites
    logic          h16, hit;
    logic [8:0]    l16;
    logic [3:0]    row_raw, row_f;
    logic [7:0]    stile;
    logic [12:0]   spr_raddr;
    logic [SW-1:0] sidx;
    logic [5:0]    sid;
    logic [7:0]    sx;
    logic [8:0]    xs, xm8;
    logic          inr;
    logic [XW-1:0] xi;
    logic [2:0]    sbit;
    logic [1:0]    sp_idx;
    logic [7:0]    spal;
    logic [CW-1:0] cnt_inc;
    logic [SPRITE_SLOTS-1:0] le;

    // output
    logic [7:0] opix;
    logic       o_inr;

    logic wr_v, wr_a;

    assign wr_v = i_cmd.idle && i_valid && (i_item.func == tsr_pkg::FUNC_VWRITE);
    assign wr_a = i_cmd.idle && i_valid && (i_item.func == tsr_pkg::FUNC_AWRITE)
                  && (i_item.mem_addr < 13'(tsr_pkg::ATTR_BYTES));

    // background pixel address
    assign x8       = 8'(r_x);
    assign use_win  = r_win && (({2'b0, x8} + 10'd7) >= {2'b0, r_wx});
    assign px       = use_win ? (x8 + 8'd7 - r_wx) : (x8 + r_scx);
    assign py       = use_win ? r_wcnt : (r_line + r_scy);
    assign map_origin = (use_win ? r_lcdc[6] : r_lcdc[3]) ? tsr_pkg::MAP_HI : tsr_pkg::MAP_LO;
    assign map_addr = map_origin + {3'b0, py[7:3], px[7:3]};
    assign tile_row = r_lcdc[4] ? {1'b0, vr_rdata, py[2:0], 1'b0}
                                : {~vr_rdata[7], vr_rdata, py[2:0], 1'b0};
    assign bg_idx   = r_lcdc[0] ? {vr_rdata[3'd7 - px[2:0]], r_lo[3'd7 - px[2:0]]} : 2'b00;

    // sprite row and pixel
    assign h16     = r_lcdc[2];
    assign l16     = {1'b0, r_line} + 9'd16;
    assign hit     = (l16 >= {1'b0, r_y}) && (l16 < ({1'b0, r_y} + (h16 ? 9'd16 : 9'd8)));
    assign cnt_inc = r_cnt + CW'(1);
    assign row_raw = 4'(l16 - {1'b0, r_y});
    assign row_f   = at_rdata[6] ? (h16 ? ~row_raw : {1'b0, ~row_raw[2:0]}) : row_raw;
    assign stile   = h16 ? {r_tile[7:1], row_f[3]} : r_tile;
    assign spr_raddr = {1'b0, stile, row_f[2:0], 1'b0};
    assign sidx    = SW'(r_cnt - CW'(1));
    assign sid     = r_sid[sidx];
    assign sx      = r_sx[sidx];
    assign xs      = {1'b0, sx} + {6'b0, r_p};
    assign xm8     = xs - 9'd8;
    assign inr     = (xs >= 9'd8) && ({1'b0, xm8} < 10'(LINE_WIDTH));
    assign xi      = XW'(xm8);
    assign sbit    = r_flags[5] ? r_p : (3'd7 - r_p);
    assign sp_idx  = {r_hi[sbit], r_lo[sbit]};
    assign spal    = r_flags[4] ? r_obp1 : r_obp0;

    // output gather
    assign opix  = {r_g, r_q[2:0]};
    assign o_inr = ({1'b0, opix} < 9'(LINE_WIDTH));

    // video memory
    assign vr_we    = i_cmd.clr || wr_v;
    assign vr_waddr = i_cmd.clr ? r_clr : i_item.mem_addr;
    assign vr_wdata = i_cmd.clr ? 8'd0 : i_item.mem_data;

    always_comb begin
        vr_raddr = map_addr;
        if (i_cmd.bg1) begin
            vr_raddr = tile_row;
        end else if (i_cmd.bg2 || i_cmd.pa4) begin
            vr_raddr = r_raddr + 13'd1;
        end else if (i_cmd.pa3) begin
            vr_raddr = spr_raddr;
        end
    end

    // attribute memory
    assign at_we    = (i_cmd.clr && (r_clr < 13'(tsr_pkg::ATTR_BYTES))) || wr_a;
    assign at_waddr = i_cmd.clr ? r_clr[7:0] : i_item.mem_addr[7:0];
    assign at_wdata = i_cmd.clr ? 8'd0 : i_item.mem_data;

    always_comb begin
        at_raddr = {r_e, 2'd0};
        if (i_cmd.sc1) begin
            at_raddr = {r_e, 2'd1};
        end else if (i_cmd.pa0) begin
            at_raddr = {sid, 2'd0};
        end else if (i_cmd.pa1) begin
            at_raddr = {sid, 2'd2};
        end else if (i_cmd.pa2) begin
            at_raddr = {sid, 2'd3};
        end
    end

    // line buffers
    assign bb_we    = i_cmd.bg3;
    assign bb_waddr = r_x;
    assign bb_wdata = bg_idx;
    assign bb_raddr = xi;

    assign sh_we    = i_cmd.bg3 || (i_cmd.pp1 && inr && (sp_idx != 2'd0)
                      && !(r_flags[7] && (bb_rdata != 2'd0)));
    assign sh_waddr = i_cmd.bg3 ? r_x : xi;
    assign sh_wdata = i_cmd.bg3 ? tsr_pkg::shade_of(r_bgp, bg_idx)
                                : tsr_pkg::shade_of(spal, sp_idx);
    assign sh_raddr = XW'(opix);

    tsr_ram #(.WIDTH(8), .DEPTH(tsr_pkg::VRAM_BYTES)) u_vram (
        .i_clk(i_clk), .i_we(vr_we), .i_waddr(vr_waddr), .i_wdata(vr_wdata),
        .i_raddr(vr_raddr), .o_rdata(vr_rdata)
    );

    tsr_ram #(.WIDTH(8), .DEPTH(tsr_pkg::ATTR_BYTES)) u_attr (
        .i_clk(i_clk), .i_we(at_we), .i_waddr(at_waddr), .i_wdata(at_wdata),
        .i_raddr(at_raddr), .o_rdata(at_rdata)
    );

    tsr_ram #(.WIDTH(2), .DEPTH(LINE_WIDTH)) u_bgbuf (
        .i_clk(i_clk), .i_we(bb_we), .i_waddr(bb_waddr), .i_wdata(bb_wdata),
        .i_raddr(bb_raddr), .o_rdata(bb_rdata)
    );

    tsr_ram #(.WIDTH(2), .DEPTH(LINE_WIDTH)) u_shbuf (
        .i_clk(i_clk), .i_we(sh_we), .i_waddr(sh_waddr), .i_wdata(sh_wdata),
        .i_raddr(sh_raddr), .o_rdata(sh_rdata)
    );

    // sorted insert: keep entries with x <= new x, new one next, rest move up
    always_comb begin
        for (int j = 0; j < SPRITE_SLOTS; j++) begin
            le[j] = (CW'(j) < r_cnt) && (r_sx[j] <= at_rdata);
        end
        for (int j = 0; j < SPRITE_SLOTS; j++) begin
            n_sid[j] = r_sid[j];
            n_sx[j]  = r_sx[j];
            if (!le[j]) begin
                if (j == 0) begin
                    n_sid[j] = r_e;
                    n_sx[j]  = at_rdata;
                end else if (le[j-1]) begin
                    n_sid[j] = r_e;
                    n_sx[j]  = at_rdata;
                end else begin
                    n_sid[j] = r_sid[j-1];
                    n_sx[j]  = r_sx[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_x      <= '0;
            r_e      <= '0;
            r_cnt    <= '0;
            r_p      <= '0;
            r_q      <= '0;
            r_g      <= '0;
            r_wcnt   <= '0;
            r_ovalid <= 1'b0;
            r_lcdc   <= tsr_pkg::LCDC_RST;
            r_scy    <= '0;
            r_scx    <= '0;
            r_bgp    <= tsr_pkg::BGP_RST;
            r_obp0   <= tsr_pkg::OBP_RST;
            r_obp1   <= tsr_pkg::OBP_RST;
            r_wy     <= '0;
            r_wx     <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_clr <= r_clr + 13'd1;
            end
            if (i_cmd.start) begin
                r_x   <= '0;
                r_e   <= '0;
                r_cnt <= '0;
                r_p   <= '0;
                r_q   <= '0;
                r_g   <= '0;
                if (i_item.line == 8'd0) begin
                    r_wcnt <= '0;
                end
            end
            if (i_cmd.bg3 && !o_st.x_last) begin
                r_x <= r_x + XW'(1);
            end
            if (i_cmd.win && r_lcdc[0] && r_win && ({2'b0, r_wx} < 10'(LINE_WIDTH + 7))) begin
                r_wcnt <= r_wcnt + 8'd1;
            end
            if (i_cmd.sc2) begin
                r_e <= r_e + 6'd1;
                if (hit) begin
                    r_cnt <= cnt_inc;
                end
            end
            if (i_cmd.pp1) begin
                r_p <= r_p + 3'd1;
                if (o_st.p_last) begin
                    r_cnt <= r_cnt - CW'(1);
                end
            end
            if (i_cmd.orr && !o_st.q_last) begin
                r_q <= r_q + 4'd1;
            end
            if (i_cmd.out_load) begin
                r_q <= '0;
                r_g <= r_g + 5'd1;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tsr_pkg::CFG_LCDC: r_lcdc <= i_cfg_data;
                    tsr_pkg::CFG_SCY:  r_scy  <= i_cfg_data;
                    tsr_pkg::CFG_SCX:  r_scx  <= i_cfg_data;
                    tsr_pkg::CFG_BGP:  r_bgp  <= i_cfg_data;
                    tsr_pkg::CFG_OBP0: r_obp0 <= i_cfg_data;
                    tsr_pkg::CFG_OBP1: r_obp1 <= i_cfg_data;
                    tsr_pkg::CFG_WY:   r_wy   <= i_cfg_data;
                    tsr_pkg::CFG_WX:   r_wx   <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_line <= i_item.line;
            r_win  <= r_lcdc[5] && (i_item.line >= r_wy) && (r_wx <= tsr_pkg::WX_MAX);
        end
        if (i_cmd.bg1) begin
            r_raddr <= tile_row;
        end
        if (i_cmd.bg2 || i_cmd.pa4) begin
            r_lo <= vr_rdata;
        end
        if (i_cmd.sc1 || i_cmd.pa1) begin
            r_y <= at_rdata;
        end
        if (i_cmd.sc2 && hit) begin
            r_sid <= n_sid;
            r_sx  <= n_sx;
        end
        if (i_cmd.pa2) begin
            r_tile <= at_rdata;
        end
        if (i_cmd.pa3) begin
            r_flags <= at_rdata;
            r_raddr <= spr_raddr;
        end
        if (i_cmd.pa5) begin
            r_hi <= vr_rdata;
        end
        if (i_cmd.orr) begin
            if (r_q != 4'd0) begin
                r_word <= {r_word[13:0], r_inr ? sh_rdata : 2'b00};
            end
            if (!o_st.q_last) begin
                r_inr <= o_inr;
            end
        end
        if (i_cmd.out_load) begin
            r_out.pixels <= r_word;
            r_out.group  <= r_g;
            r_out.last   <= o_st.g_last;
        end
    end

    assign o_st.clr_last  = (r_clr == 13'h1FFF);
    assign o_st.go        = i_valid && (i_item.func == tsr_pkg::FUNC_RENDER)
                            && ({1'b0, i_item.line} < 9'(LINE_COUNT));
    assign o_st.x_last    = (r_x == XW'(LINE_WIDTH - 1));
    assign o_st.spr_en    = r_lcdc[1];
    assign o_st.scan_done = (r_e == 6'(NE - 1))
                            || (hit && (cnt_inc == CW'(SPRITE_SLOTS)));
    assign o_st.slot_zero = (r_cnt == '0);
    assign o_st.p_last    = (r_p == 3'd7);
    assign o_st.q_last    = (r_q == 4'd8);
    assign o_st.g_last    = (r_g == 5'(GROUPS - 1));
    assign o_st.out_free  = !r_ovalid || !i_stall;

    assign o_valid = r_ovalid;
    assign o_item  = r_out;

    `TSR_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(SPRITE_SLOTS), "sprite list overflow")
    `TSR_ASSERT_IMP(a_x_bound, i_clk, i_rst_n, 1'b1, {1'b0, x8} < 9'(LINE_WIDTH), "pixel index out of line")
    `TSR_ASSERT_IMP(a_last_group, i_clk, i_rst_n, r_ovalid && r_out.last, r_out.group == 5'(GROUPS - 1), "last flag on wrong group")
    `TSR_ASSERT_NXT(a_out_held, i_clk, i_rst_n, r_ovalid && i_stall && !i_cmd.out_load, r_ovalid, "result dropped while stalled")

endmodule

`default_nettype wire

// ===== hw/rtl/tile_scanline_renderer_core.sv =====
// ----------------------------------------------------------------------------
// Tile scanline renderer core
// Input items write video memory, write sprite attributes or render a line;
// a render returns one item per eight-pixel group, leftmost pixel in the
// top bits, with a last flag on the final group.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low. The user must write registers through the cfg port only while the
// block idles; the block itself does not enforce this. After reset a
// clearing pass over all 8192 video memory addresses zeroes video and
// attribute memory; the input stalls during it. A write item leaves the
// block idle and ready for the next item. The length of a render is set by
// the single read port of video memory: three reads per background pixel
// and two per sprite row. Results leave through one output register; while
// the receiver stalls the render holds at the next group, and the last
// group may wait there while the next item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_scanline_renderer_core #(
    parameter int LINE_WIDTH     = tsr_pkg::LINE_WIDTH_DEF,
    parameter int LINE_COUNT     = tsr_pkg::LINE_COUNT_DEF,
    parameter int SPRITE_SLOTS   = tsr_pkg::SPRITE_SLOTS_DEF,
    parameter int SPRITE_ENTRIES = tsr_pkg::SPRITE_ENTRIES_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_stall,
    input  tsr_pkg::t_in   i_item,
    output logic           o_valid,
    input  wire            i_stall,
    output tsr_pkg::t_out  o_item,
    input  wire            i_cfg_we,
    input  wire  [2:0]     i_cfg_idx,
    input  wire  [7:0]     i_cfg_data
);

    tsr_pkg::t_cmd cmd;
    tsr_pkg::t_st  st;

    tsr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    tsr_dp #(
        .LINE_WIDTH     (LINE_WIDTH),
        .LINE_COUNT     (LINE_COUNT),
        .SPRITE_SLOTS   (SPRITE_SLOTS),
        .SPRITE_ENTRIES (SPRITE_ENTRIES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_st       (st),
        .i_valid    (i_valid),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item)
    );

    assign o_stall = !cmd.idle;

endmodule

`default_nettype wire
